[sv/dda_pkg.sv]
// Shared types and codes for the DDA line rasterizer.
package dda_pkg;

  // Operation codes carried on the input word.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Control from the sequencer to a bit-serial divider.
  typedef struct packed {
    logic load;
    logic shift;
  } div_ctrl_t;

endpackage

[sv/dda_div.sv]
// Restoring divider, one quotient bit per cycle while shift is asserted.
module dda_div import dda_pkg::*; #(
  parameter int unsigned NUM_W = 31,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk_i,
  input  div_ctrl_t        ctrl_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Numerator bits leave at the top of quo_q while quotient bits enter below.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    if (ctrl_i.load) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (ctrl_i.shift) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;

endmodule

[sv/dda_line_rasterizer.sv]
// DDA line rasterizer top level: sequencer, bit-serial accumulators, output register.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_ready_o | operation, x/y_start, x/y_finish
//   out     | output    | out_valid_o/out_ready_i | pixel_valid, pixel_x, pixel_y, last_pixel
//
// A start of a non-empty line loads the restoring dividers, which make one increment bit
// per cycle, then applies the endpoint signs to the increments. An advance on an active
// line runs the bit-serial accumulator adders. A zero-length start or an idle advance goes
// straight to the output register. One word is in work at a time.
// Reset clears the line state to idle and empties the output register. A stalled output
// register holds its word; the next input word is still taken, and its result waits.
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_finish_i,
  input  logic [COORD_BITS-1:0] y_finish_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  pixel_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);

  localparam int unsigned ACC_W = COORD_BITS + FRAC_BITS;
  localparam int unsigned NUM_W = ACC_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SIGN,
    S_ADD,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ACC_W-1:0]      x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [ACC_W-1:0]      x_inc_q, x_inc_d, y_inc_q, y_inc_d;
  logic                  x_carry_q, x_carry_d, y_carry_q, y_carry_d;
  logic [COORD_BITS-1:0] steps_q, steps_d;
  logic                  active_q, active_d;
  logic                  x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic [COORD_BITS-1:0] x_mag_q, x_mag_d, y_mag_q, y_mag_d;
  logic [COORD_BITS-1:0] step_q, step_d;
  logic                  res_valid_q, res_valid_d, res_last_q, res_last_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_pv_q, out_pv_d, out_last_q, out_last_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  logic                  in_neg_x, in_neg_y;
  logic [COORD_BITS-1:0] in_mag_x, in_mag_y, in_step;
  logic [NUM_W-1:0]      x_num, y_num, x_quo, y_quo;
  logic                  x_sum, y_sum, x_cout, y_cout;
  logic [COORD_BITS-1:0] x_pix, y_pix;
  div_ctrl_t             div_ctrl;

  // Endpoint differences of the incoming word.
  assign in_neg_x = x_finish_i < x_start_i;
  assign in_neg_y = y_finish_i < y_start_i;
  assign in_mag_x = in_neg_x ? x_start_i - x_finish_i : x_finish_i - x_start_i;
  assign in_mag_y = in_neg_y ? y_start_i - y_finish_i : y_finish_i - y_start_i;
  assign in_step  = (in_mag_x > in_mag_y) ? in_mag_x : in_mag_y;

  // Rounded-to-nearest increment magnitude: (|d| * 2^F + step/2) / step.
  assign x_num = NUM_W'({x_mag_q, {FRAC_BITS{1'b0}}}) + NUM_W'(step_q >> 1);
  assign y_num = NUM_W'({y_mag_q, {FRAC_BITS{1'b0}}}) + NUM_W'(step_q >> 1);

  assign div_ctrl.load  = (state_q == S_LOAD);
  assign div_ctrl.shift = (state_q == S_DIV);

  dda_div #(.NUM_W(NUM_W), .DEN_W(COORD_BITS)) u_div_x (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (x_num),
    .den_i  (step_q),
    .quo_o  (x_quo)
  );

  dda_div #(.NUM_W(NUM_W), .DEN_W(COORD_BITS)) u_div_y (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (y_num),
    .den_i  (step_q),
    .quo_o  (y_quo)
  );

  // One full adder per axis; accumulator and increment rotate right each cycle of S_ADD.
  assign x_sum  = x_acc_q[0] ^ x_inc_q[0] ^ x_carry_q;
  assign y_sum  = y_acc_q[0] ^ y_inc_q[0] ^ y_carry_q;
  assign x_cout = (x_acc_q[0] & x_inc_q[0]) | (x_carry_q & (x_acc_q[0] ^ x_inc_q[0]));
  assign y_cout = (y_acc_q[0] & y_inc_q[0]) | (y_carry_q & (y_acc_q[0] ^ y_inc_q[0]));

  // Round to nearest: add half an LSB at the binary point.
  assign x_pix = x_acc_q[ACC_W-1:FRAC_BITS] + COORD_BITS'(x_acc_q[FRAC_BITS-1]);
  assign y_pix = y_acc_q[ACC_W-1:FRAC_BITS] + COORD_BITS'(y_acc_q[FRAC_BITS-1]);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_acc_d     = x_acc_q;
    y_acc_d     = y_acc_q;
    x_inc_d     = x_inc_q;
    y_inc_d     = y_inc_q;
    x_carry_d   = x_carry_q;
    y_carry_d   = y_carry_q;
    steps_d     = steps_q;
    active_d    = active_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    x_mag_d     = x_mag_q;
    y_mag_d     = y_mag_q;
    step_d      = step_q;
    res_valid_d = res_valid_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q;
    out_pv_d    = out_pv_q;
    out_last_d  = out_last_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_START) begin
            x_acc_d     = {x_start_i, {FRAC_BITS{1'b0}}};
            y_acc_d     = {y_start_i, {FRAC_BITS{1'b0}}};
            x_inc_d     = '0;
            y_inc_d     = '0;
            x_neg_d     = in_neg_x;
            y_neg_d     = in_neg_y;
            x_mag_d     = in_mag_x;
            y_mag_d     = in_mag_y;
            step_d      = in_step;
            steps_d     = in_step;
            active_d    = (in_step != '0);
            res_valid_d = 1'b1;
            res_last_d  = (in_step == '0);
            state_d     = (in_step == '0) ? S_DONE : S_LOAD;
          end else if (!active_q) begin
            res_valid_d = 1'b0;
            res_last_d  = 1'b0;
            state_d     = S_DONE;
          end else begin
            steps_d     = steps_q - COORD_BITS'(1);
            active_d    = (steps_q != COORD_BITS'(1));
            res_valid_d = 1'b1;
            res_last_d  = (steps_q == COORD_BITS'(1));
            x_carry_d   = 1'b0;
            y_carry_d   = 1'b0;
            cnt_d       = CNT_W'(ACC_W - 1);
            state_d     = S_ADD;
          end
        end
      end
      S_LOAD: begin
        cnt_d   = CNT_W'(NUM_W - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_SIGN;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_SIGN: begin
        x_inc_d = x_neg_q ? {ACC_W{1'b0}} - x_quo[ACC_W-1:0] : x_quo[ACC_W-1:0];
        y_inc_d = y_neg_q ? {ACC_W{1'b0}} - y_quo[ACC_W-1:0] : y_quo[ACC_W-1:0];
        state_d = S_DONE;
      end
      S_ADD: begin
        x_acc_d   = {x_sum, x_acc_q[ACC_W-1:1]};
        y_acc_d   = {y_sum, y_acc_q[ACC_W-1:1]};
        x_inc_d   = {x_inc_q[0], x_inc_q[ACC_W-1:1]};
        y_inc_d   = {y_inc_q[0], y_inc_q[ACC_W-1:1]};
        x_carry_d = x_cout;
        y_carry_d = y_cout;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pv_d    = res_valid_q;
          out_last_d  = res_last_q;
          out_x_d     = res_valid_q ? x_pix : '0;
          out_y_d     = res_valid_q ? y_pix : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      x_inc_q     <= '0;
      y_inc_q     <= '0;
      x_carry_q   <= 1'b0;
      y_carry_q   <= 1'b0;
      steps_q     <= '0;
      active_q    <= 1'b0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      x_mag_q     <= '0;
      y_mag_q     <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_pv_q    <= 1'b0;
      out_last_q  <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
      x_inc_q     <= x_inc_d;
      y_inc_q     <= y_inc_d;
      x_carry_q   <= x_carry_d;
      y_carry_q   <= y_carry_d;
      steps_q     <= steps_d;
      active_q    <= active_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      x_mag_q     <= x_mag_d;
      y_mag_q     <= y_mag_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
      res_last_q  <= res_last_d;
      out_valid_q <= out_valid_d;
      out_pv_q    <= out_pv_d;
      out_last_q  <= out_last_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = out_pv_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign last_pixel_o  = out_last_q;

endmodule

[sv/dda_checker.sv]
// Port-level checks for the DDA line rasterizer, bound to the top level.
module dda_checker #(
  parameter int unsigned COORD_BITS = 10
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  pixel_valid_o,
  input logic [COORD_BITS-1:0] pixel_x_o,
  input logic [COORD_BITS-1:0] pixel_y_o,
  input logic                  last_pixel_o
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pixel_valid_o) && $stable(last_pixel_o))
    else $error("output word changed while stalled");

  // A word without a pixel carries zeros and no last flag.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |-> pixel_x_o == '0 && pixel_y_o == '0 && !last_pixel_o)
    else $error("idle result carries nonzero fields");

  // One word in work at a time: ready drops after each accepted word.
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in work");

  // An accepted word yields no result in the very next cycle from an empty output.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind dda_line_rasterizer dda_checker #(.COORD_BITS(COORD_BITS)) u_dda_checker (.*);
